>>> rtl/ntt_pkg.sv
package ntt_pkg;

	// default configuration
	localparam int MAX_DOTS_DEF  = 15;
	localparam int TOK_DEPTH_DEF = 4;

	// field widths
	localparam int KIND_W = 3;
	localparam int FREQ_W = 15;
	localparam int DUR_W  = 20;
	localparam int UNIT_W = 16;
	localparam int OCT_W  = 4;
	localparam int NOTE_W = 3;
	localparam int DOT_W  = 4;
	localparam int BASE_W = 14;
	localparam int Q_W    = 17;

	// top octave index and semitone factors in q16
	localparam logic [OCT_W-1:0] TOP_OCTAVE = 4'd9;
	localparam logic [Q_W-1:0]   SHARP_Q16  = 17'd69433;
	localparam logic [Q_W-1:0]   FLAT_Q16   = 17'd61858;

	typedef enum logic [KIND_W-1:0] {
		KIND_TONE    = 3'd0,
		KIND_PAUSE   = 3'd1,
		KIND_RESTART = 3'd2,
		KIND_STOP    = 3'd3,
		KIND_BAD     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ACC_NATURAL = 2'd0,
		ACC_SHARP   = 2'd1,
		ACC_FLAT    = 2'd2
	} acc_t;

	// one finished token handed from the parser to the tone unit
	typedef struct packed {
		kind_t             kind;
		logic [OCT_W-1:0]  octave;
		logic [NOTE_W-1:0] note;
		acc_t              acc;
		logic [DOT_W-1:0]  dots;
	} tok_t;

	// top octave frequency per letter, a = 0 .. g = 6
	function automatic logic [BASE_W-1:0] top_hz(input logic [NOTE_W-1:0] note);
		logic [BASE_W-1:0] hz;
		case (note)
			3'd0: hz = 14'd14080;
			3'd1: hz = 14'd15804;
			3'd2: hz = 14'd8372;
			3'd3: hz = 14'd9397;
			3'd4: hz = 14'd10548;
			3'd5: hz = 14'd11175;
			3'd6: hz = 14'd12544;
			default: hz = 14'd14080;
		endcase
		return hz;
	endfunction

endpackage

>>> rtl/ntt_front.sv
module ntt_front #(
	parameter int MAX_DOTS = ntt_pkg::MAX_DOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [7:0]            char_code,
	input  logic                  tok_full,
	output logic                  tok_push,
	output ntt_pkg::tok_t         tok
);

	typedef enum logic [1:0] {
		CLS_TONE    = 2'd0,
		CLS_PAUSE   = 2'd1,
		CLS_RESTART = 2'd2
	} cls_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UG    = 8'h47;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CASE_OFS = 8'h20;
	localparam logic [ntt_pkg::DOT_W-1:0] DOT_MAX = ntt_pkg::DOT_W'(MAX_DOTS);

	logic [1:0]                  pos_q, pos_d;
	cls_t                        cls_q, cls_d;
	logic [ntt_pkg::OCT_W-1:0]   oct_q, oct_d;
	logic [ntt_pkg::NOTE_W-1:0]  note_q, note_d;
	ntt_pkg::acc_t               acc_q, acc_d;
	logic [ntt_pkg::DOT_W-1:0]   dots_q, dots_d;
	logic                        bad_q, bad_d;
	logic                        halted_q, halted_d;
	logic                        is_ws;
	logic [7:0]                  upper;

	assign is_ws = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
	assign upper = (char_code >= CH_LA && char_code <= CH_LZ) ? char_code - CASE_OFS
		: char_code;

	// token parser
	always_comb begin
		pos_d    = pos_q;
		cls_d    = cls_q;
		oct_d    = oct_q;
		note_d   = note_q;
		acc_d    = acc_q;
		dots_d   = dots_q;
		bad_d    = bad_q;
		halted_d = halted_q;
		tok_push = 1'b0;
		tok      = '{kind: ntt_pkg::KIND_BAD, octave: oct_q, note: note_q,
			acc: acc_q, dots: dots_q};
		if (push && !tok_full && !halted_q) begin
			if (is_ws) begin
				if (pos_q != 2'd0) begin
					tok_push = 1'b1;
					if (cls_q == CLS_RESTART) begin
						tok.kind = ntt_pkg::KIND_RESTART;
					end else if (cls_q == CLS_PAUSE) begin
						tok.kind = ntt_pkg::KIND_PAUSE;
					end else if (bad_q || pos_q < 2'd2) begin
						tok.kind = ntt_pkg::KIND_BAD;
					end else begin
						tok.kind = ntt_pkg::KIND_TONE;
					end
					pos_d  = 2'd0;
					cls_d  = CLS_TONE;
					oct_d  = '0;
					note_d = '0;
					acc_d  = ntt_pkg::ACC_NATURAL;
					dots_d = '0;
					bad_d  = 1'b0;
				end
			end else if (pos_q == 2'd0 && char_code == CH_SEMI) begin
				halted_d = 1'b1;
				tok_push = 1'b1;
				tok.kind = ntt_pkg::KIND_STOP;
			end else begin
				if (pos_q == 2'd0) begin
					if (char_code == CH_COLON) begin
						cls_d = CLS_RESTART;
					end else if (char_code == CH_DASH) begin
						cls_d = CLS_PAUSE;
					end else begin
						cls_d = CLS_TONE;
						if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
							oct_d = ntt_pkg::OCT_W'(char_code - CH_ZERO);
						end else begin
							bad_d = 1'b1;
						end
					end
				end else if (pos_q == 2'd1 && cls_q == CLS_TONE) begin
					if (upper >= CH_UA && upper <= CH_UG) begin
						note_d = ntt_pkg::NOTE_W'(upper - CH_UA);
					end else begin
						bad_d = 1'b1;
					end
				end else if (pos_q == 2'd2 && cls_q == CLS_TONE) begin
					if (char_code == CH_HASH) begin
						acc_d = ntt_pkg::ACC_SHARP;
					end else if (char_code == CH_LB) begin
						acc_d = ntt_pkg::ACC_FLAT;
					end
				end
				if (char_code == CH_DOT && cls_d != CLS_RESTART && dots_q < DOT_MAX) begin
					dots_d = dots_q + 1'b1;
				end
				if (pos_q != 2'd3) begin
					pos_d = pos_q + 1'b1;
				end
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			cls_q    <= CLS_TONE;
			oct_q    <= '0;
			note_q   <= '0;
			acc_q    <= ntt_pkg::ACC_NATURAL;
			dots_q   <= '0;
			bad_q    <= 1'b0;
			halted_q <= 1'b0;
		end else begin
			pos_q    <= pos_d;
			cls_q    <= cls_d;
			oct_q    <= oct_d;
			note_q   <= note_d;
			acc_q    <= acc_d;
			dots_q   <= dots_d;
			bad_q    <= bad_d;
			halted_q <= halted_d;
		end
	end

`ifndef SYNTHESIS
	// nothing leaves the parser once stopped
	assert property (@(posedge clk) disable iff (!arst_n) halted_q |-> !tok_push)
		else $error("token emitted after stop");
	// a stop token always latches the halt
	assert property (@(posedge clk) disable iff (!arst_n)
		tok_push && tok.kind == ntt_pkg::KIND_STOP |=> halted_q)
		else $error("stop did not halt the parser");
`endif

endmodule

>>> rtl/ntt_tok_queue.sv
module ntt_tok_queue #(
	parameter int DEPTH = ntt_pkg::TOK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  ntt_pkg::tok_t wr_tok,
	output logic          full,
	input  logic          rd_en,
	output ntt_pkg::tok_t rd_tok,
	output logic          empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ntt_pkg::tok_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_wr, do_rd;

	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_tok = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	// fill count stays within the storage
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(DEPTH))
		else $error("token queue overfilled");
`endif

endmodule

>>> rtl/ntt_back.sv
module ntt_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          unit_duration_we,
	input  logic [ntt_pkg::UNIT_W-1:0]    unit_duration_ms,
	input  logic                          tok_empty,
	input  ntt_pkg::tok_t                 tok,
	output logic                          tok_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [ntt_pkg::KIND_W-1:0]    kind,
	output logic [ntt_pkg::FREQ_W-1:0]    frequency_hz,
	output logic [ntt_pkg::DUR_W-1:0]     duration_ms
);

	typedef struct packed {
		ntt_pkg::kind_t             kind;
		logic [ntt_pkg::FREQ_W-1:0] freq;
		logic [ntt_pkg::DUR_W-1:0]  dur;
	} res_t;

	localparam int PROD_W = ntt_pkg::BASE_W + ntt_pkg::Q_W;
	localparam int DMUL_W = ntt_pkg::UNIT_W + ntt_pkg::DOT_W + 1;

	logic [ntt_pkg::UNIT_W-1:0]  unit_q;
	logic                        valid_s1;
	ntt_pkg::kind_t              kind_s1;
	logic [ntt_pkg::BASE_W-1:0]  base_s1;
	ntt_pkg::acc_t               acc_s1;
	logic [ntt_pkg::DOT_W-1:0]   dots_s1;
	res_t                        res_q [2];
	logic                        wr_ptr_q, rd_ptr_q;
	logic [1:0]                  cnt_q;
	logic                        res_full, s1_ready, res_wr, res_rd;
	logic [ntt_pkg::BASE_W-1:0]  base_d;
	logic [ntt_pkg::Q_W-1:0]     factor;
	logic [PROD_W-1:0]           prod;
	logic [DMUL_W-1:0]           dur_prod;
	res_t                        res_d;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign s1_ready = !valid_s1 || !res_full;
	assign tok_pop  = !tok_empty && s1_ready;
	assign res_wr   = valid_s1 && !res_full;
	assign res_rd   = pop && !empty;

	// unit duration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= '0;
		end else if (unit_duration_we) begin
			unit_q <= unit_duration_ms;
		end
	end

	// stage 1: letter lookup and octave shift
	assign base_d = ntt_pkg::top_hz(tok.note) >> (ntt_pkg::TOP_OCTAVE - tok.octave);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= tok_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop) begin
			kind_s1 <= tok.kind;
			base_s1 <= base_d;
			acc_s1  <= tok.acc;
			dots_s1 <= tok.dots;
		end
	end

	// stage 2: semitone scaling and duration
	assign factor   = (acc_s1 == ntt_pkg::ACC_SHARP) ? ntt_pkg::SHARP_Q16 : ntt_pkg::FLAT_Q16;
	assign prod     = PROD_W'(base_s1) * PROD_W'(factor);
	assign dur_prod = DMUL_W'(unit_q) * (DMUL_W'(dots_s1) + 1'b1);

	always_comb begin
		res_d.kind = kind_s1;
		res_d.freq = '0;
		res_d.dur  = '0;
		case (kind_s1)
			ntt_pkg::KIND_TONE: begin
				if (acc_s1 == ntt_pkg::ACC_NATURAL) begin
					res_d.freq = ntt_pkg::FREQ_W'(base_s1);
				end else begin
					res_d.freq = prod[16 +: ntt_pkg::FREQ_W];
				end
				res_d.dur = dur_prod[ntt_pkg::DUR_W-1:0];
			end
			ntt_pkg::KIND_PAUSE: begin
				res_d.dur = dur_prod[ntt_pkg::DUR_W-1:0];
			end
			default: begin
				res_d.dur = '0;
			end
		endcase
	end

	// result queue, two entries
	always_ff @(posedge clk) begin
		if (res_wr) begin
			res_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (res_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (res_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (res_wr && !res_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (res_rd && !res_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign kind         = res_q[rd_ptr_q].kind;
	assign frequency_hz = res_q[rd_ptr_q].freq;
	assign duration_ms  = res_q[rd_ptr_q].dur;

`ifndef SYNTHESIS
	// only tones carry a frequency
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind != ntt_pkg::KIND_TONE |-> frequency_hz == '0)
		else $error("frequency on a non-tone result");
	// the scaling stage never holds more than the result queue can take
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("result queue overfilled");
`endif

endmodule

>>> rtl/note_text_to_tone_unit.sv
// path: a token-ending byte's result passes the token queue, stage 1 and the result queue
// a stop byte's result takes the same path to the output ports
// throughput: one byte per cycle while the token queue is not full; two-stage tone unit
// reset: arst_n clears parser state, halt flag, unit duration and both queues at once
module note_text_to_tone_unit #(
	parameter int MAX_DOTS  = ntt_pkg::MAX_DOTS_DEF,
	parameter int TOK_DEPTH = ntt_pkg::TOK_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    char_code,
	output logic                          empty,
	input  logic                          pop,
	output logic [ntt_pkg::KIND_W-1:0]    kind,
	output logic [ntt_pkg::FREQ_W-1:0]    frequency_hz,
	output logic [ntt_pkg::DUR_W-1:0]     duration_ms,
	input  logic                          unit_duration_we,
	input  logic [ntt_pkg::UNIT_W-1:0]    unit_duration_ms
);

	logic          tok_push, tok_pop, tok_full, tok_empty;
	ntt_pkg::tok_t tok_in, tok_out;

	assign full = tok_full;

	// parser
	ntt_front #(
		.MAX_DOTS (MAX_DOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_code (char_code),
		.tok_full  (tok_full),
		.tok_push  (tok_push),
		.tok       (tok_in)
	);

	// token queue between parser and tone unit
	ntt_tok_queue #(
		.DEPTH (TOK_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (tok_push),
		.wr_tok (tok_in),
		.full   (tok_full),
		.rd_en  (tok_pop),
		.rd_tok (tok_out),
		.empty  (tok_empty)
	);

	// tone unit
	ntt_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.unit_duration_we (unit_duration_we),
		.unit_duration_ms (unit_duration_ms),
		.tok_empty        (tok_empty),
		.tok              (tok_out),
		.tok_pop          (tok_pop),
		.empty            (empty),
		.pop              (pop),
		.kind             (kind),
		.frequency_hz     (frequency_hz),
		.duration_ms      (duration_ms)
	);

endmodule
